// File: sv/srl_pkg.sv
`default_nettype none
package srl_pkg;

   localparam int DEPTH_DEF         = 64;
   localparam int PAYLOAD_WIDTH_DEF = 64;

   localparam int KEY_W    = 31;
   localparam int PAY_W    = 64;
   localparam int POS_W    = 7;
   localparam int MODE_W   = 4;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 120;
   localparam int RSP_W    = 112;

   localparam logic [MODE_W-1:0] MODE_APPEND     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_FRONT      = 4'd1;
   localparam logic [MODE_W-1:0] MODE_SORTED     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_READ       = 4'd3;
   localparam logic [MODE_W-1:0] MODE_FIND       = 4'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_REM_FIRST  = 4'd6;
   localparam logic [MODE_W-1:0] MODE_REM_LAST   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_SWAP       = 4'd8;
   localparam logic [MODE_W-1:0] MODE_RANGE      = 4'd9;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   typedef enum logic [2:0] {
      CMD_HOLD    = 3'd0,
      CMD_COMPARE = 3'd1,
      CMD_OPEN    = 3'd2,
      CMD_CLOSE   = 3'd3,
      CMD_SWAP    = 3'd4
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } cmd_type;

endpackage
`default_nettype wire

// File: sv/srl_cell.sv
`default_nettype none
module srl_cell #(
   parameter int DEPTH         = srl_pkg::DEPTH_DEF,
   parameter int PAYLOAD_WIDTH = srl_pkg::PAYLOAD_WIDTH_DEF,
   parameter int IDX           = 0
) (
   input  wire                               clock,
   input  srl_pkg::cmd_type                  cmd,
   input  wire [$clog2(DEPTH)-1:0]           pos,
   input  wire [$clog2(DEPTH+1)-1:0]         count,
   input  wire [srl_pkg::KEY_W-1:0]          left_key,
   input  wire [PAYLOAD_WIDTH-1:0]           left_pay,
   input  wire [srl_pkg::KEY_W-1:0]          right_key,
   input  wire [PAYLOAD_WIDTH-1:0]           right_pay,
   input  wire [srl_pkg::KEY_W-1:0]          swap_key,
   input  wire [PAYLOAD_WIDTH-1:0]           swap_pay,
   output logic [srl_pkg::KEY_W-1:0]         key,
   output logic [PAYLOAD_WIDTH-1:0]          pay,
   output logic                              eq,
   output logic                              lt
);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic [srl_pkg::KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]  pay_ff, pay_in;
   logic                      eq_ff, eq_in, lt_ff, lt_in;
   logic                      valid;

   assign valid = CNT_W'(IDX) < count;

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      eq_in  = eq_ff;
      lt_in  = lt_ff;
      case (cmd.op)
         srl_pkg::CMD_COMPARE: begin
            eq_in = valid && (key_ff == cmd.key);
            lt_in = valid && (key_ff < cmd.key);
         end
         srl_pkg::CMD_OPEN: begin
            if (MY_IDX == pos) begin
               key_in = cmd.key;
               pay_in = cmd.payload[PAYLOAD_WIDTH-1:0];
            end else if (MY_IDX > pos) begin
               key_in = left_key;
               pay_in = left_pay;
            end
         end
         srl_pkg::CMD_CLOSE: begin
            if (MY_IDX >= pos) begin
               key_in = right_key;
               pay_in = right_pay;
            end
         end
         srl_pkg::CMD_SWAP: begin
            if (MY_IDX == pos) begin
               key_in = swap_key;
               pay_in = swap_pay;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
      eq_ff  <= eq_in;
      lt_ff  <= lt_in;
   end

   assign key = key_ff;
   assign pay = pay_ff;
   assign eq  = eq_ff;
   assign lt  = lt_ff;

endmodule
`default_nettype wire

// File: sv/sequential_record_list_top.sv
// Flow: an accepted request passes through the compare, execute and deliver steps;
//   range removal adds one shift step per removed record.
// A new request is taken only after the previous result has been loaded into the result
//   register, which waits on rsp_tready while it still holds an untaken result.
// The cell chain compares all keys in parallel and shifts one slot per cycle.
// Reset: synchronous, active high; clears the record count and handshake state.
`default_nettype none
module sequential_record_list_top #(
   parameter int DEPTH         = srl_pkg::DEPTH_DEF,
   parameter int PAYLOAD_WIDTH = srl_pkg::PAYLOAD_WIDTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // mode[3:0], key[34:4], payload[98:35], position[105:99], range_end[112:106]
   input  wire [srl_pkg::REQ_W-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // status[1:0], found_key[32:2], found_payload[96:33], entry_count[103:97],
   // is_full[104], is_empty[105]
   output logic [srl_pkg::RSP_W-1:0]  rsp_tdata
);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int CMP_W = (CNT_W > srl_pkg::POS_W) ? CNT_W : srl_pkg::POS_W;
   localparam int KW    = srl_pkg::KEY_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, remain_ff, remain_in;
   logic [srl_pkg::MODE_W-1:0] mode_ff;
   logic [KW-1:0]              key_ff;
   logic [srl_pkg::PAY_W-1:0]  payload_ff;
   logic [srl_pkg::POS_W-1:0]  pos_ff, end_ff;
   logic [srl_pkg::STATUS_W-1:0] res_st_ff, res_st_in;
   logic [KW-1:0]              res_key_ff, res_key_in;
   logic [srl_pkg::PAY_W-1:0]  res_pay_ff, res_pay_in;
   logic                       rsp_valid_ff;
   logic [srl_pkg::RSP_W-1:0]  rsp_data_ff;

   srl_pkg::cmd_type cmd;
   logic [IDX_W-1:0] cell_pos;

   logic [KW-1:0]            cell_key [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] cell_pay [DEPTH];
   logic [DEPTH-1:0]         eq_vec, lt_vec;

   logic [IDX_W-1:0] found_idx, ins_idx, rd_idx, last_idx;
   logic [CMP_W-1:0] pos_c, end_c, cnt_c;
   logic             out_free;

   function automatic logic [IDX_W-1:0] first_set(input logic [DEPTH-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = DEPTH-1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   assign found_idx = first_set(eq_vec);
   assign ins_idx   = first_set(~lt_vec);
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign pos_c     = CMP_W'(pos_ff);
   assign end_c     = CMP_W'(end_ff);
   assign cnt_c     = CMP_W'(count_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         srl_cell #(.DEPTH(DEPTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH), .IDX(g)) u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .pos       (cell_pos),
            .count     (count_ff),
            .left_key  (cell_key[(g == 0) ? 0 : g-1]),
            .left_pay  (cell_pay[(g == 0) ? 0 : g-1]),
            .right_key (cell_key[(g == DEPTH-1) ? g : g+1]),
            .right_pay (cell_pay[(g == DEPTH-1) ? g : g+1]),
            .swap_key  (cell_key[last_idx]),
            .swap_pay  (cell_pay[last_idx]),
            .key       (cell_key[g]),
            .pay       (cell_pay[g]),
            .eq        (eq_vec[g]),
            .lt        (lt_vec[g])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      res_st_in  = res_st_ff;
      res_key_in = res_key_ff;
      res_pay_in = res_pay_ff;
      cmd.op      = srl_pkg::CMD_HOLD;
      cmd.key     = key_ff;
      cmd.payload = payload_ff;
      cell_pos   = '0;
      rd_idx     = found_idx;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op   = srl_pkg::CMD_COMPARE;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_st_in  = srl_pkg::ST_DONE;
            res_key_in = '0;
            res_pay_in = '0;
            state_in   = S_DONE;
            case (mode_ff)
               srl_pkg::MODE_APPEND, srl_pkg::MODE_FRONT, srl_pkg::MODE_SORTED: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_st_in = srl_pkg::ST_REJECT;
                  end else begin
                     cmd.op   = srl_pkg::CMD_OPEN;
                     count_in = count_ff + CNT_W'(1);
                     if (mode_ff == srl_pkg::MODE_APPEND) cell_pos = IDX_W'(count_ff);
                     else if (mode_ff == srl_pkg::MODE_SORTED) cell_pos = ins_idx;
                  end
               end
               srl_pkg::MODE_READ: begin
                  rd_idx = IDX_W'(pos_ff - srl_pkg::POS_W'(1));
                  if (pos_c == '0 || pos_c > cnt_c) begin
                     res_st_in = srl_pkg::ST_REJECT;
                  end else begin
                     res_key_in = cell_key[rd_idx];
                     res_pay_in = srl_pkg::PAY_W'(cell_pay[rd_idx]);
                  end
               end
               srl_pkg::MODE_FIND, srl_pkg::MODE_REMOVE, srl_pkg::MODE_SWAP: begin
                  if (count_ff == '0) begin
                     res_st_in = srl_pkg::ST_REJECT;
                  end else if (!(|eq_vec)) begin
                     res_st_in = srl_pkg::ST_MISS;
                  end else begin
                     res_key_in = cell_key[rd_idx];
                     res_pay_in = srl_pkg::PAY_W'(cell_pay[rd_idx]);
                     cell_pos   = found_idx;
                     if (mode_ff == srl_pkg::MODE_REMOVE) begin
                        cmd.op   = srl_pkg::CMD_CLOSE;
                        count_in = count_ff - CNT_W'(1);
                     end else if (mode_ff == srl_pkg::MODE_SWAP) begin
                        cmd.op   = srl_pkg::CMD_SWAP;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               srl_pkg::MODE_REM_FIRST: begin
                  if (count_ff == '0) res_st_in = srl_pkg::ST_REJECT;
                  else begin
                     cmd.op   = srl_pkg::CMD_CLOSE;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               srl_pkg::MODE_REM_LAST: begin
                  if (count_ff == '0) res_st_in = srl_pkg::ST_REJECT;
                  else count_in = count_ff - CNT_W'(1);
               end
               srl_pkg::MODE_RANGE: begin
                  if (count_ff == '0 || pos_c == '0 || end_c > cnt_c || pos_c > end_c) begin
                     res_st_in = srl_pkg::ST_REJECT;
                  end else begin
                     remain_in = CNT_W'(end_c - pos_c + CMP_W'(1));
                     state_in  = S_SHIFT;
                  end
               end
               default: res_st_in = srl_pkg::ST_REJECT;
            endcase
         end
         S_SHIFT: begin
            cmd.op    = srl_pkg::CMD_CLOSE;
            cell_pos  = IDX_W'(pos_ff - srl_pkg::POS_W'(1));
            count_in  = count_ff - CNT_W'(1);
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      res_st_ff  <= res_st_in;
      res_key_ff <= res_key_in;
      res_pay_ff <= res_pay_in;
      if (req_tvalid && req_tready) begin
         mode_ff    <= req_tdata[3:0];
         key_ff     <= req_tdata[34:4];
         payload_ff <= req_tdata[98:35];
         pos_ff     <= req_tdata[105:99];
         end_ff     <= req_tdata[112:106];
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_data_ff <= {6'd0,
                         (count_ff == '0),
                         (count_ff == CNT_W'(DEPTH)),
                         srl_pkg::POS_W'(count_ff),
                         res_pay_ff, res_key_ff, res_st_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("record count above capacity");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_shift_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (remain_ff != '0 && count_ff != '0))
      else $error("range shift with nothing left");
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SCAN))
      else $error("request accepted without compare");

endmodule
`default_nettype wire
